// ----- sv/btat_pkg.sv -----
// shared types, constants and command codes for the blob target association table
`timescale 1ns / 1ps
package btat_pkg;
	localparam int TableDepth = 16;
	localparam int PendDepth = 16;
	localparam int CoordBits = 12;
	localparam int TimeBits = 32;
	localparam int IdxBits = $clog2(TableDepth);
	localparam int CntBits = $clog2(TableDepth + 1);
	localparam int PIdxBits = $clog2(PendDepth);
	localparam int PCntBits = $clog2(PendDepth + 1);
	localparam int AreaBits = 2 * CoordBits;

	typedef enum logic [1:0] {
		CMD_BLOB = 2'd0,
		CMD_END_FRAME = 2'd1,
		CMD_SET_BOUNDS = 2'd2,
		CMD_SELECT = 2'd3
	} cmd_t;

	localparam logic [0:0] REG_PRUNE = 1'b0;
	localparam logic [0:0] REG_MAX = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MATCH,
		ST_PRUNE,
		ST_APPEND,
		ST_CLEAR,
		ST_SEL_CHECK,
		ST_SEL_SCAN,
		ST_SEL_SET,
		ST_REPORT,
		ST_OUT
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic               latch_in;
		logic               clr_scan;
		logic               step_scan;
		logic               match_step;
		logic               blob_miss;
		logic               prune_step;
		logic               prune_finish;
		logic               check_overflow;
		logic               append_step;
		logic               clear_table;
		logic               pend_clear;
		logic               sel_check_step;
		logic               sel_scan_step;
		logic               sel_set;
		logic               report_step;
		logic               set_bounds;
		logic               load_out;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		cmd_t               cmd;
		logic               scan_done;
		logic               hit;
		logic               over;
		logic               append_done;
		logic               sel_found;
	} dp_stat_t;
endpackage

// ----- sv/blob_target_association_table.sv -----
// top level of the blob target association table
//  channel  | direction | handshake            | payload
//  in       | to block  | in_valid / in_stall  | cmd pos_x pos_y extent_w extent_h now entry_index
//  out      | from block| out_valid / out_stall| matched match_index target_count selected_*
//  cfg      | to block  | cfg_we               | cfg_index cfg_data
// one item at a time; a blob scans the n stored targets, an end of frame scans the
// n targets before, the p buffered blobs and the m targets after;
// the table scans step the single entry scan index.
// arst_n clears the table, pending count and flags; no clearing pass is needed.
// the result register lets the next item start while a result waits under out_stall;
// that item then holds in its last cycle until the waiting result is taken.
`timescale 1ns / 1ps
module blob_target_association_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [11:0] pos_x,
	input  logic [11:0] pos_y,
	input  logic [11:0] extent_w,
	input  logic [11:0] extent_h,
	input  logic [31:0] now,
	input  logic [3:0]  entry_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        matched,
	output logic [3:0]  match_index,
	output logic [4:0]  target_count,
	output logic        selected_valid,
	output logic [3:0]  selected_index,
	output logic        cleared,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	btat_pkg::dp_cmd_t  dcmd;
	btat_pkg::dp_stat_t stat;
	logic [31:0] prune_q;
	logic [4:0]  max_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prune_q <= 32'd1000;
			max_q <= 5'd8;
		end else if (cfg_we) begin
			if (cfg_index == btat_pkg::REG_PRUNE) prune_q <= cfg_data;
			if (cfg_index == btat_pkg::REG_MAX) max_q <= cfg_data[4:0];
		end
	end

	btat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .dcmd(dcmd)
	);

	btat_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .dcmd(dcmd), .stat(stat), .cmd(cmd),
		.pos_x(pos_x), .pos_y(pos_y), .extent_w(extent_w), .extent_h(extent_h),
		.now(now), .entry_index(entry_index), .prune_thr(prune_q), .max_tgt(max_q),
		.matched(matched), .match_index(match_index), .target_count(target_count),
		.selected_valid(selected_valid), .selected_index(selected_index),
		.cleared(cleared)
	);
endmodule

// ----- sv/btat_datapath.sv -----
// table storage, pending buffer and per-entry scan datapath
`timescale 1ns / 1ps
module btat_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  btat_pkg::dp_cmd_t                      dcmd,
	output btat_pkg::dp_stat_t                     stat,
	input  logic [1:0]                             cmd,
	input  logic [btat_pkg::CoordBits-1:0]         pos_x,
	input  logic [btat_pkg::CoordBits-1:0]         pos_y,
	input  logic [btat_pkg::CoordBits-1:0]         extent_w,
	input  logic [btat_pkg::CoordBits-1:0]         extent_h,
	input  logic [btat_pkg::TimeBits-1:0]          now,
	input  logic [3:0]                             entry_index,
	input  logic [btat_pkg::TimeBits-1:0]          prune_thr,
	input  logic [4:0]                             max_tgt,
	output logic                                   matched,
	output logic [3:0]                             match_index,
	output logic [4:0]                             target_count,
	output logic                                   selected_valid,
	output logic [3:0]                             selected_index,
	output logic                                   cleared
);
	localparam int TD = btat_pkg::TableDepth;
	localparam int CB = btat_pkg::CoordBits;
	localparam int IB = btat_pkg::IdxBits;
	localparam int NB = btat_pkg::CntBits;
	localparam int PB = btat_pkg::PIdxBits;
	localparam int PN = btat_pkg::PCntBits;
	localparam int AB = btat_pkg::AreaBits;
	localparam int TB = btat_pkg::TimeBits;
	// wide enough for count + pending + overflow and max_targets
	localparam int SB = (NB > PN ? NB : PN) + 2;

	// table entries as registers with a fixed-place read via the scan index
	logic [CB-1:0] rx_q [TD];
	logic [CB-1:0] ry_q [TD];
	logic [CB-1:0] rw_q [TD];
	logic [CB-1:0] rh_q [TD];
	logic [TB-1:0] tm_q [TD];
	logic [TD-1:0] paired_q, sel_q;
	logic [NB-1:0] count_q;

	// pending blobs buffer
	logic [CB-1:0] bx_q [btat_pkg::PendDepth];
	logic [CB-1:0] by_q [btat_pkg::PendDepth];
	logic [CB-1:0] bs_q [btat_pkg::PendDepth];
	logic [PN-1:0] pcount_q;
	logic          povf_q;

	// latched item
	btat_pkg::cmd_t cmd_q;
	logic [CB-1:0] px_q, py_q, ew_q, eh_q;
	logic [TB-1:0] now_q;
	logic [3:0]    eidx_q;

	// scan state
	logic [NB-1:0] i_q;      // read index
	logic [NB-1:0] j_q;      // write index for compaction/append
	logic [PN-1:0] k_q;      // pending read index
	logic          hit_q;
	logic [IB-1:0] hit_idx_q;
	logic          over_q;
	logic          best_v_q;
	logic [IB-1:0] best_q;
	logic [AB-1:0] best_area_q;
	logic          sel_found_q;
	logic [IB-1:0] sel_idx_q;
	logic          clr_q;

	logic [IB-1:0] ii;
	logic [CB:0]   xe, ye;
	logic          inside_rect;
	logic [TB-1:0] age;
	logic          keep;
	logic [AB-1:0] area;
	logic [SB-1:0] total, limit;
	logic          idx_ok;

	assign ii = i_q[IB-1:0];
	// containment test for the current entry
	assign xe = {1'b0, rx_q[ii]} + {1'b0, rw_q[ii]};
	assign ye = {1'b0, ry_q[ii]} + {1'b0, rh_q[ii]};
	assign inside_rect = (rx_q[ii] <= px_q) && ({1'b0, px_q} < xe)
		&& (ry_q[ii] <= py_q) && ({1'b0, py_q} < ye);
	// wrapping age for pruning
	assign age = now_q - tm_q[ii];
	assign keep = paired_q[ii] || (age < prune_thr);
	// area for selection
	always_ff @(posedge clk) begin
		area <= AB'(rw_q[ii]) * AB'(rh_q[ii]);
	end
	// overflow limit
	assign limit = (max_tgt < 5'(TD)) ? SB'(max_tgt) : SB'(TD);
	assign total = SB'(j_q) + SB'(pcount_q) + SB'(povf_q);
	assign idx_ok = ({1'b0, eidx_q} < 5'(TD)) && (NB'(eidx_q) < count_q);

	assign stat.cmd = cmd_q;
	assign stat.scan_done = (i_q >= count_q);
	assign stat.hit = hit_q;
	assign stat.over = over_q;
	assign stat.append_done = (k_q >= pcount_q) || (j_q >= NB'(TD));
	assign stat.sel_found = sel_found_q;

	// input latch and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= btat_pkg::CMD_BLOB;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			hit_q <= 1'b0;
			over_q <= 1'b0;
			best_v_q <= 1'b0;
			sel_found_q <= 1'b0;
			clr_q <= 1'b0;
		end else begin
			if (dcmd.latch_in) begin
				cmd_q <= btat_pkg::cmd_t'(cmd);
				hit_q <= 1'b0;
				clr_q <= 1'b0;
				sel_found_q <= 1'b0;
			end
			if (dcmd.clr_scan) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
				best_v_q <= 1'b0;
			end
			if (dcmd.step_scan) i_q <= i_q + 1'b1;
			if (dcmd.match_step && !paired_q[ii] && inside_rect) hit_q <= 1'b1;
			if (dcmd.prune_step && keep) j_q <= j_q + 1'b1;
			if (dcmd.check_overflow) over_q <= (total > limit);
			if (dcmd.append_step) begin
				j_q <= j_q + 1'b1;
				k_q <= k_q + 1'b1;
			end
			if (dcmd.clear_table) clr_q <= 1'b1;
			if (dcmd.sel_check_step && sel_q[ii]) sel_found_q <= 1'b1;
			if (dcmd.sel_scan_step && (!best_v_q || area > best_area_q)) best_v_q <= 1'b1;
			if (dcmd.report_step && sel_q[ii]) sel_found_q <= 1'b1;
		end
	end

	// payload-only registers
	always_ff @(posedge clk) begin
		if (dcmd.latch_in) begin
			px_q <= pos_x;
			py_q <= pos_y;
			ew_q <= extent_w;
			eh_q <= extent_h;
			now_q <= now;
			eidx_q <= entry_index;
		end
		if (dcmd.match_step && !paired_q[ii] && inside_rect) hit_idx_q <= ii;
		if (dcmd.sel_scan_step && (!best_v_q || area > best_area_q)) begin
			best_q <= ii;
			best_area_q <= area;
		end
		if ((dcmd.sel_check_step || dcmd.report_step) && sel_q[ii] && !sel_found_q)
			sel_idx_q <= ii;
		if (dcmd.sel_set) sel_idx_q <= best_q;
		// compaction move
		if (dcmd.prune_step && keep) begin
			rx_q[j_q[IB-1:0]] <= rx_q[ii];
			ry_q[j_q[IB-1:0]] <= ry_q[ii];
			rw_q[j_q[IB-1:0]] <= rw_q[ii];
			rh_q[j_q[IB-1:0]] <= rh_q[ii];
			tm_q[j_q[IB-1:0]] <= tm_q[ii];
		end
		if (dcmd.match_step && !paired_q[ii] && inside_rect) tm_q[ii] <= now_q;
		if (dcmd.append_step) begin
			rx_q[j_q[IB-1:0]] <= bx_q[k_q[PB-1:0]];
			ry_q[j_q[IB-1:0]] <= by_q[k_q[PB-1:0]];
			rw_q[j_q[IB-1:0]] <= bs_q[k_q[PB-1:0]];
			rh_q[j_q[IB-1:0]] <= bs_q[k_q[PB-1:0]];
			tm_q[j_q[IB-1:0]] <= now_q;
		end
		if (dcmd.set_bounds && idx_ok) begin
			rx_q[eidx_q[IB-1:0]] <= px_q;
			ry_q[eidx_q[IB-1:0]] <= py_q;
			rw_q[eidx_q[IB-1:0]] <= ew_q;
			rh_q[eidx_q[IB-1:0]] <= eh_q;
		end
		if (dcmd.blob_miss && pcount_q < PN'(btat_pkg::PendDepth)) begin
			bx_q[pcount_q[PB-1:0]] <= px_q;
			by_q[pcount_q[PB-1:0]] <= py_q;
			bs_q[pcount_q[PB-1:0]] <= ew_q;
		end
	end

	// flags, count and pending bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paired_q <= '0;
			sel_q <= '0;
			count_q <= '0;
			pcount_q <= '0;
			povf_q <= 1'b0;
		end else begin
			if (dcmd.match_step && !paired_q[ii] && inside_rect) paired_q[ii] <= 1'b1;
			if (dcmd.blob_miss) begin
				if (pcount_q < PN'(btat_pkg::PendDepth)) pcount_q <= pcount_q + 1'b1;
				else povf_q <= 1'b1;
			end
			if (dcmd.prune_step) begin
				if (keep) begin
					sel_q[j_q[IB-1:0]] <= sel_q[ii];
					paired_q[j_q[IB-1:0]] <= 1'b0;
				end
			end
			if (dcmd.prune_finish) begin
				// drop everything past the kept prefix
				for (int e = 0; e < TD; e++) begin
					if (NB'(e) >= j_q) begin
						sel_q[e] <= 1'b0;
						paired_q[e] <= 1'b0;
					end
				end
				count_q <= j_q;
			end
			if (dcmd.append_step) begin
				sel_q[j_q[IB-1:0]] <= 1'b0;
				paired_q[j_q[IB-1:0]] <= 1'b0;
				count_q <= j_q + 1'b1;
			end
			if (dcmd.clear_table) begin
				sel_q <= '0;
				paired_q <= '0;
				count_q <= '0;
			end
			// pending buffer empties once appended or cleared
			if (dcmd.pend_clear) begin
				pcount_q <= '0;
				povf_q <= 1'b0;
			end
			if (dcmd.sel_set && best_v_q) sel_q[best_q] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (dcmd.load_out) begin
			matched <= hit_q;
			match_index <= hit_q ? 4'(hit_idx_q) : 4'd0;
			target_count <= 5'(count_q);
			selected_valid <= sel_found_q;
			selected_index <= sel_found_q ? 4'(sel_idx_q) : 4'd0;
			cleared <= clr_q;
		end
	end
endmodule

// ----- sv/btat_ctrl.sv -----
// sequencing state machine for the table scans
`timescale 1ns / 1ps
module btat_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  btat_pkg::dp_stat_t   stat,
	output btat_pkg::dp_cmd_t    dcmd
);
	btat_pkg::state_t state_q, state_d;
	logic ov_q, ov_d;
	// area is registered, so each compare waits for the area of the current index to be fetched
	logic lag_q, lag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btat_pkg::ST_IDLE;
			ov_q <= 1'b0;
			lag_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
			lag_q <= lag_d;
		end
	end

	assign out_valid = ov_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ov_d = ov_q && out_stall;
		lag_d = 1'b0;
		dcmd = '0;
		in_stall = 1'b1;
		case (state_q)
			btat_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					dcmd.latch_in = 1'b1;
					dcmd.clr_scan = 1'b1;
					state_d = btat_pkg::ST_MATCH;
				end
			end
			btat_pkg::ST_MATCH: begin
				case (stat.cmd)
					btat_pkg::CMD_BLOB: begin
						if (stat.hit) state_d = btat_pkg::ST_REPORT;
						else if (stat.scan_done) begin
							dcmd.blob_miss = 1'b1;
							state_d = btat_pkg::ST_REPORT;
						end else begin
							dcmd.match_step = 1'b1;
							dcmd.step_scan = 1'b1;
						end
						if (stat.hit || stat.scan_done) dcmd.clr_scan = 1'b1;
					end
					btat_pkg::CMD_END_FRAME: state_d = btat_pkg::ST_PRUNE;
					btat_pkg::CMD_SET_BOUNDS: begin
						dcmd.set_bounds = 1'b1;
						state_d = btat_pkg::ST_REPORT;
					end
					default: state_d = btat_pkg::ST_SEL_CHECK;
				endcase
			end
			btat_pkg::ST_PRUNE: begin
				if (stat.scan_done) begin
					dcmd.prune_finish = 1'b1;
					dcmd.check_overflow = 1'b1;
					state_d = btat_pkg::ST_APPEND;
				end else begin
					dcmd.prune_step = 1'b1;
					dcmd.step_scan = 1'b1;
				end
			end
			btat_pkg::ST_APPEND: begin
				if (stat.over) state_d = btat_pkg::ST_CLEAR;
				else if (stat.append_done) begin
					dcmd.clr_scan = 1'b1;
					dcmd.pend_clear = 1'b1;
					state_d = btat_pkg::ST_SEL_CHECK;
				end else dcmd.append_step = 1'b1;
			end
			btat_pkg::ST_CLEAR: begin
				dcmd.clear_table = 1'b1;
				dcmd.pend_clear = 1'b1;
				dcmd.clr_scan = 1'b1;
				state_d = btat_pkg::ST_SEL_CHECK;
			end
			btat_pkg::ST_SEL_CHECK: begin
				if (stat.sel_found) begin
					dcmd.clr_scan = 1'b1;
					state_d = btat_pkg::ST_REPORT;
				end else if (stat.scan_done) begin
					dcmd.clr_scan = 1'b1;
					state_d = btat_pkg::ST_SEL_SCAN;
				end else begin
					dcmd.sel_check_step = 1'b1;
					dcmd.step_scan = 1'b1;
				end
			end
			btat_pkg::ST_SEL_SCAN: begin
				// fetch the area first, then compare
				if (lag_q) dcmd.sel_scan_step = 1'b1;
				if (stat.scan_done && lag_q) state_d = btat_pkg::ST_SEL_SET;
				else if (!lag_q) begin
					if (stat.scan_done) state_d = btat_pkg::ST_SEL_SET;
					else lag_d = 1'b1;
				end else begin
					dcmd.step_scan = 1'b1;
				end
			end
			btat_pkg::ST_SEL_SET: begin
				dcmd.sel_set = 1'b1;
				dcmd.clr_scan = 1'b1;
				state_d = btat_pkg::ST_REPORT;
			end
			btat_pkg::ST_REPORT: begin
				if (stat.sel_found || stat.scan_done) state_d = btat_pkg::ST_OUT;
				else begin
					dcmd.report_step = 1'b1;
					dcmd.step_scan = 1'b1;
				end
			end
			btat_pkg::ST_OUT: begin
				if (!ov_q || !out_stall) begin
					dcmd.load_out = 1'b1;
					ov_d = 1'b1;
					state_d = btat_pkg::ST_IDLE;
				end
			end
			default: state_d = btat_pkg::ST_IDLE;
		endcase
	end
endmodule
